>>> hdl/ramm_pkg.sv
// Shared constants, types and arithmetic helpers for the running-average motion mask.
`timescale 1ns / 1ps

package ramm_pkg;

   // Field widths
   localparam int IDX_W   = 18;
   localparam int PIX_W   = 8;
   localparam int ALPHA_W = 7;
   localparam int THR_W   = 8;
   localparam int CSR_W   = 8;

   // Background store covers one full frame
   localparam int FRAME_PIXELS = 262144;

   // Stream word widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;

   // BT.601 gray weights in Q14
   localparam int GRAY_SUM_W = 23;
   localparam int GRAY_SHIFT = 14;
   localparam logic [GRAY_SUM_W-1:0] W_RED      = GRAY_SUM_W'(4899);
   localparam logic [GRAY_SUM_W-1:0] W_GREEN    = GRAY_SUM_W'(9617);
   localparam logic [GRAY_SUM_W-1:0] W_BLUE     = GRAY_SUM_W'(1868);
   localparam logic [GRAY_SUM_W-1:0] GRAY_HALF  = GRAY_SUM_W'(8192);

   // Blend in percent: sum <= 100*255 + 50, fits 15 bits
   localparam int BLEND_W = 15;
   localparam logic [ALPHA_W-1:0] ALPHA_MAX  = ALPHA_W'(100);
   localparam logic [BLEND_W-1:0] ROUND_HALF = BLEND_W'(50);

   // Divide by 100 as multiply by 5243 and shift by 19, exact below 43699
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = 28;
   localparam logic [PROD_W-1:0] RECIP = PROD_W'(5243);

   // Reset values of the control registers
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(10);
   localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(10);

   // Control register indexes
   typedef enum logic [0:0] {
      CSR_ALPHA  = 1'b0,
      CSR_THRESH = 1'b1
   } csr_index_type;

   // Gray level of one RGB pixel, rounded to 8 bits
   function automatic logic [PIX_W-1:0] to_gray(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
      logic [GRAY_SUM_W-1:0] sum;
      sum = W_RED * GRAY_SUM_W'(r) + W_GREEN * GRAY_SUM_W'(g)
          + W_BLUE * GRAY_SUM_W'(b) + GRAY_HALF;
      return sum[GRAY_SHIFT +: PIX_W];
   endfunction

   // Weighted sum (100-a)*old + a*gray + 50, before the divide by 100
   function automatic logic [BLEND_W-1:0] blend_sum(input logic [PIX_W-1:0]   old_bg,
                                                    input logic [PIX_W-1:0]   gray,
                                                    input logic [ALPHA_W-1:0] alpha);
      logic [ALPHA_W-1:0] keep;
      keep = ALPHA_MAX - alpha;
      return BLEND_W'(keep) * BLEND_W'(old_bg) + BLEND_W'(alpha) * BLEND_W'(gray)
           + ROUND_HALF;
   endfunction

endpackage

>>> hdl/ramm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module ramm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/running_average_motion_mask_unit.sv
// Top level of the running-average motion mask: gray conversion, background update, mask.
`timescale 1ns / 1ps

// Takes one RGB pixel word per clock while req_tready is high and returns one mask word
// per pixel, in order. Each word passes through the input, gray, blend, divide and result
// registers, and the result register holds while the result side stalls. The background
// byte for each raster index lives in an on-chip RAM of one frame (262144 bytes); its
// read-modify-write spans four pipeline stages (read, blend, divide by 100, write back).
// A pixel whose index matches one still in those four stages is held off with req_tready
// low until that pixel has written back, so a stream that repeats an index within four
// words is slowed; a raster stream runs at one pixel per clock while the result side is not stalling.
// The store needs no clearing after reset: until the first word carrying tlast has been
// taken, the old background is the pixel's own gray value. Control registers must be
// written only while the block is idle; the block itself does not enforce this.
module running_average_motion_mask_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Control registers
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [ramm_pkg::CSR_W-1:0]         csr_wdata,
   // Pixel words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ramm_pkg::REQ_TDATA_W-1:0]   req_tdata,  // pixel_index, red, green, blue
   input  logic                               req_tlast,  // frame_end
   // Mask words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ramm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // out_index
   output logic                               rsp_tuser,  // moving
   output logic                               rsp_tlast   // out_frame_end
);

   localparam int IDX_W   = ramm_pkg::IDX_W;
   localparam int PIX_W   = ramm_pkg::PIX_W;
   localparam int ALPHA_W = ramm_pkg::ALPHA_W;
   localparam int THR_W   = ramm_pkg::THR_W;

   // Control registers
   logic [ALPHA_W-1:0] alpha_ff;
   logic [THR_W-1:0]   thresh_ff;
   logic [ALPHA_W-1:0] alpha_sat;

   // Pipeline state
   logic                          primed_ff;
   logic                          s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_v_ff;
   logic [IDX_W-1:0]              s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff, rsp_idx_ff;
   logic                          s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff, rsp_last_ff;
   logic [PIX_W-1:0]              s1_red_ff, s1_green_ff, s1_blue_ff;
   logic                          s1_use_ff, s2_use_ff;
   logic [PIX_W-1:0]              s2_gray_ff, s3_gray_ff, s4_gray_ff;
   logic [ramm_pkg::BLEND_W-1:0]  s3_sum_ff;
   logic [ramm_pkg::PROD_W-1:0]   s4_prod_ff;
   logic                          rsp_moving_ff;

   // Next values and handshake terms
   logic                          out_ready, s4_free, s3_free, s2_free, s1_free;
   logic                          hazard, req_fire;
   logic [IDX_W-1:0]              req_idx;
   logic [PIX_W-1:0]              s2_gray_in, old_bg, new_bg, diff;
   logic [ramm_pkg::BLEND_W-1:0]  s3_sum_in;
   logic [ramm_pkg::PROD_W-1:0]   s4_prod_in;
   logic                          moving_in;
   logic [PIX_W-1:0]              store_rd_data;

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ramm_pkg::ALPHA_RESET;
         thresh_ff <= ramm_pkg::THR_RESET;
      end else if (csr_we) begin
         unique case (ramm_pkg::csr_index_type'(csr_index))
            ramm_pkg::CSR_ALPHA:  alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            ramm_pkg::CSR_THRESH: thresh_ff <= csr_wdata[THR_W-1:0];
            default:              alpha_ff  <= alpha_ff;
         endcase
      end
   end

   // Learning rate above 100 percent saturates
   assign alpha_sat = (alpha_ff > ramm_pkg::ALPHA_MAX) ? ramm_pkg::ALPHA_MAX : alpha_ff;

   // Stage flow: a stage takes a new word when empty or when it is handing on its own
   assign out_ready = !rsp_v_ff || rsp_tready;
   assign s4_free   = !s4_v_ff || out_ready;
   assign s3_free   = !s3_v_ff || s4_free;
   assign s2_free   = !s2_v_ff || s3_free;
   assign s1_free   = !s1_v_ff || s2_free;

   // Hold off a pixel whose background byte is still being updated
   assign req_idx = req_tdata[IDX_W-1:0];
   assign hazard  = (s1_v_ff && (s1_idx_ff == req_idx))
                 || (s2_v_ff && (s2_idx_ff == req_idx))
                 || (s3_v_ff && (s3_idx_ff == req_idx))
                 || (s4_v_ff && (s4_idx_ff == req_idx));

   assign req_tready = s1_free && !hazard;
   assign req_fire   = req_tvalid && req_tready;

   // Primed once the first frame's last word has been taken
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else if (req_fire && req_tlast) begin
         primed_ff <= 1'b1;
      end
   end

   // Stage 1: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_free) begin
         s1_v_ff <= req_tvalid && !hazard;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_idx_ff   <= req_idx;
         s1_red_ff   <= req_tdata[IDX_W +: PIX_W];
         s1_green_ff <= req_tdata[IDX_W + PIX_W +: PIX_W];
         s1_blue_ff  <= req_tdata[IDX_W + 2*PIX_W +: PIX_W];
         s1_last_ff  <= req_tlast;
         s1_use_ff   <= primed_ff;
      end
   end

   // Stage 2: gray level, background read issued from stage 1
   assign s2_gray_in = ramm_pkg::to_gray(s1_red_ff, s1_green_ff, s1_blue_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_idx_ff  <= s1_idx_ff;
         s2_gray_ff <= s2_gray_in;
         s2_last_ff <= s1_last_ff;
         s2_use_ff  <= s1_use_ff;
      end
   end

   // Stage 3: weighted sum of old background and gray
   assign old_bg    = s2_use_ff ? store_rd_data : s2_gray_ff;
   assign s3_sum_in = ramm_pkg::blend_sum(old_bg, s2_gray_ff, alpha_sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_free) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_idx_ff  <= s2_idx_ff;
         s3_gray_ff <= s2_gray_ff;
         s3_last_ff <= s2_last_ff;
         s3_sum_ff  <= s3_sum_in;
      end
   end

   // Stage 4: divide by 100 through the reciprocal
   assign s4_prod_in = ramm_pkg::PROD_W'(s3_sum_ff) * ramm_pkg::RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (s4_free) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_free) begin
         s4_idx_ff  <= s3_idx_ff;
         s4_gray_ff <= s3_gray_ff;
         s4_last_ff <= s3_last_ff;
         s4_prod_ff <= s4_prod_in;
      end
   end

   // New background, write-back and mask decision
   assign new_bg    = s4_prod_ff[ramm_pkg::RECIP_SHIFT +: PIX_W];
   assign diff      = (new_bg >= s4_gray_ff) ? (new_bg - s4_gray_ff) : (s4_gray_ff - new_bg);
   assign moving_in = diff > thresh_ff;

   ramm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (ramm_pkg::FRAME_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (s4_v_ff && out_ready),
      .wr_addr (s4_idx_ff),
      .wr_data (new_bg),
      .rd_en   (s1_v_ff && s2_free),
      .rd_addr (s1_idx_ff),
      .rd_data (store_rd_data)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_idx_ff    <= s4_idx_ff;
         rsp_moving_ff <= moving_in;
         rsp_last_ff   <= s4_last_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = ramm_pkg::RSP_TDATA_W'(rsp_idx_ff);
   assign rsp_tuser  = rsp_moving_ff;
   assign rsp_tlast  = rsp_last_ff;

   // When stages 1 and 2 both hold words, the stage 1 index differs from stage 2 and any valid stage 3
   a_no_index_overlap: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff) |-> (s1_idx_ff != s2_idx_ff && s1_idx_ff != s3_idx_ff
                                 || !s3_v_ff && s1_idx_ff != s2_idx_ff))
      else $error("two words with the same index in the update stages");

   // Divided blend never exceeds one byte
   a_quotient_in_range: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff |-> (s4_prod_ff[ramm_pkg::PROD_W-1] == 1'b0))
      else $error("background quotient out of range");

   // Taking a frame's last word primes the background
   a_primed_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> primed_ff)
      else $error("not primed after frame end");

   // A stalled result holds its mask bit
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !rsp_tready) |=> (rsp_v_ff && $stable(rsp_moving_ff)))
      else $error("stalled result changed");

endmodule
